@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// when ante holds, cons must hold in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants, types and the tanh table for the segment interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ssi_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int FRAC_BITS   = 16;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int DIVD_W = FRAC_BITS + 2;
    localparam int DCNT_W = $clog2(DIVD_W);
    localparam int FIFO_DEPTH = 2;

    // tanh table: Q1.16 entries over [0,8] at step 1/64
    localparam int TANH_STEPS = 512;
    localparam int TANH_HALF  = TANH_STEPS / 2;
    localparam int TAB_AW     = $clog2(TANH_STEPS);
    localparam int TAB_W      = 17;
    localparam logic [TAB_W-1:0] TANH_ONE = TAB_W'(65536);
    localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

    localparam logic [7:0] CFG_SAMPLES = 8'd0;
    localparam logic [7:0] CFG_MODE    = 8'd1;

    typedef enum logic [1:0] {
        MODE_BOUNDARY = 2'd0,
        MODE_LINEAR   = 2'd1,
        MODE_DRIVE    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        FS_IDLE = 2'd0,
        FS_DIV  = 2'd1,
        FS_PUSH = 2'd2
    } t_front_state;

    typedef struct packed {
        logic signed [31:0]   xs;
        logic signed [31:0]   xb;
        logic signed [31:0]   xe;
        logic signed [31:0]   xd;
        logic [15:0]          gain;
        logic signed [31:0]   lo;
        logic signed [31:0]   hi;
        logic [31:0]          span;
        t_mode                mode;
        logic [CNT_W-1:0]     cnt;
        logic [FRAC_BITS:0]   q;
        logic [CNT_W-1:0]     r_inc;
        logic [CNT_W-1:0]     d2;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef logic [TAB_W-1:0] t_tab_even [0:TANH_HALF];
    typedef logic [TAB_W-1:0] t_tab_odd  [0:TANH_HALF-1];

    // shift-subtract quotient, only used while building the constant table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(tanh(k/64) * 65536) from a series for exp(-k/32)
    function automatic logic [TAB_W-1:0] tanh_entry(input int k);
        logic [63:0] f;
        logic [63:0] term;
        longint      sum;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] res;
        f    = 64'(k & 31) << 27;
        sum  = longint'(64'd1 << 32);
        term = 64'd1 << 32;
        for (int i = 1; i <= 12; i++) begin
            term = udiv64((term * f) >> 32, 64'(i));
            if ((i & 1) == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        e = 64'(sum);
        for (int n = 0; n < (k >> 5); n++) begin
            e = (e * EXP_M1_Q32 + 64'h8000_0000) >> 32;
        end
        num = ((64'd1 << 32) - e) << 16;
        den = (64'd1 << 32) + e;
        res = udiv64(2 * num + den, 2 * den);
        return TAB_W'(res);
    endfunction

    function automatic t_tab_even build_even();
        t_tab_even tab;
        for (int m = 0; m <= TANH_HALF; m++) tab[m] = tanh_entry(2 * m);
        return tab;
    endfunction

    function automatic t_tab_odd build_odd();
        t_tab_odd tab;
        for (int m = 0; m < TANH_HALF; m++) tab[m] = tanh_entry(2 * m + 1);
        return tab;
    endfunction

    // even and odd entries in separate banks: neighbors always differ in bank
    localparam t_tab_even TANH_EVEN = build_even();
    localparam t_tab_odd  TANH_ODD  = build_odd();

endpackage
`default_nettype wire

@@ design/ssi_fifo.sv @@
// ----------------------------------------------------------------------------
// ssi_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssi_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ssi_pkg::t_job       i_job,
    input  wire logic           i_pop,
    output ssi_pkg::t_job       o_job,
    output ssi_pkg::t_fifo_stat o_stat
);
    import ssi_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_job            r_mem [0:FIFO_DEPTH-1];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // depth is a power of two: pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    `ASSERT_ALWAYS(a_fifo_bound, i_clk, i_rst_n, r_cnt <= (PW+1)'(FIFO_DEPTH))
endmodule
`default_nettype wire

@@ design/ssi_front.sv @@
// ----------------------------------------------------------------------------
// ssi_front
// Takes step requests, sorts endpoints, works out the step of t per sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssi_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_x_start,
    input  wire logic signed [31:0] i_x_boundary,
    input  wire logic signed [31:0] i_x_end,
    input  wire logic signed [31:0] i_drive_point,
    input  wire logic signed [15:0] i_gain,
    input  wire logic [6:0]         i_sample_count,
    input  wire logic [1:0]         i_mode,
    output logic                    o_push,
    output ssi_pkg::t_job           o_job,
    input  ssi_pkg::t_fifo_stat     i_stat
);
    import ssi_pkg::*;

    t_front_state        r_state, n_state;
    t_job                r_job, n_job;
    logic                r_cache_vld, n_cache_vld;
    logic [CNT_W-1:0]    r_cache_cnt, n_cache_cnt;
    logic [FRAC_BITS:0]  r_cache_q, n_cache_q;
    logic [CNT_W-1:0]    r_cache_r, n_cache_r;
    logic [CNT_W:0]      r_rem, n_rem;
    logic [DIVD_W-1:0]   r_quo, n_quo;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;

    logic [CNT_W-1:0]    cnt_sat;
    logic [CNT_W:0]      rem_sh;

    always_comb begin
        if (i_sample_count == '0) cnt_sat = CNT_W'(1);
        else if (CNT_W'(i_sample_count) > CNT_W'(MAX_SAMPLES)) cnt_sat = CNT_W'(MAX_SAMPLES);
        else cnt_sat = CNT_W'(i_sample_count);
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_cache_vld = r_cache_vld;
        n_cache_cnt = r_cache_cnt;
        n_cache_q   = r_cache_q;
        n_cache_r   = r_cache_r;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dcnt      = r_dcnt;
        o_ready     = 1'b0;
        o_push      = 1'b0;
        o_job       = r_job;
        o_job.q     = r_cache_q;
        o_job.r_inc = r_cache_r;
        rem_sh      = {r_rem[CNT_W-1:0], (r_dcnt == DCNT_W'(DIVD_W - 1))};
        unique case (r_state)
            FS_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_job.xs   = i_x_start;
                    n_job.xb   = i_x_boundary;
                    n_job.xe   = i_x_end;
                    n_job.xd   = i_drive_point;
                    n_job.gain = i_gain[15] ? 16'd0 : i_gain;
                    n_job.lo   = (i_x_start < i_x_end) ? i_x_start : i_x_end;
                    n_job.hi   = (i_x_start < i_x_end) ? i_x_end : i_x_start;
                    n_job.span = 32'(n_job.hi - n_job.lo);
                    unique case (i_mode)
                        2'd1:    n_job.mode = MODE_LINEAR;
                        2'd2:    n_job.mode = MODE_DRIVE;
                        default: n_job.mode = MODE_BOUNDARY;
                    endcase
                    n_job.cnt  = cnt_sat;
                    n_job.d2   = CNT_W'((cnt_sat - 1'b1) << 1);
                    n_job.q    = '0;
                    n_job.r_inc = '0;
                    n_rem  = '0;
                    n_quo  = '0;
                    n_dcnt = DCNT_W'(DIVD_W - 1);
                    if (r_cache_vld && r_cache_cnt == cnt_sat) n_state = FS_PUSH;
                    else n_state = FS_DIV;
                end
            end
            FS_DIV: begin
                // restoring division of 2^(FRAC_BITS+1) by 2*(S-1), a bit a cycle
                if (r_job.d2 == '0) begin
                    n_cache_q   = '0;
                    n_cache_r   = '0;
                    n_cache_cnt = r_job.cnt;
                    n_cache_vld = 1'b1;
                    n_state     = FS_PUSH;
                end else begin
                    if (rem_sh >= {1'b0, r_job.d2}) begin
                        n_rem = rem_sh - {1'b0, r_job.d2};
                        n_quo = {r_quo[DIVD_W-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_quo = {r_quo[DIVD_W-2:0], 1'b0};
                    end
                    if (r_dcnt == '0) begin
                        n_cache_q   = n_quo[FRAC_BITS:0];
                        n_cache_r   = n_rem[CNT_W-1:0];
                        n_cache_cnt = r_job.cnt;
                        n_cache_vld = 1'b1;
                        n_state     = FS_PUSH;
                    end else begin
                        n_dcnt = r_dcnt - 1'b1;
                    end
                end
            end
            FS_PUSH: begin
                if (!i_stat.full) begin
                    o_push  = 1'b1;
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_cache_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cache_vld <= n_cache_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_cache_cnt <= n_cache_cnt;
        r_cache_q   <= n_cache_q;
        r_cache_r   <= n_cache_r;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_dcnt      <= n_dcnt;
    end

    `ASSERT_IMPLY(a_push_hit, i_clk, i_rst_n, o_push, r_cache_vld && r_cache_cnt == r_job.cnt)
endmodule
`default_nettype wire

@@ design/ssi_back.sv @@
// ----------------------------------------------------------------------------
// ssi_back
// Sample sequencer and evaluation pipeline with running min/max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ssi_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  ssi_pkg::t_job           i_job,
    input  ssi_pkg::t_fifo_stat     i_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_sample_value,
    output logic                    o_last_of_step,
    output logic signed [31:0]      o_range_min,
    output logic signed [31:0]      o_range_max
);
    import ssi_pkg::*;

    localparam int LP_W  = FRAC_BITS + 35;
    localparam int ARG_W = FRAC_BITS + 20;
    localparam int TI_W  = ARG_W - FRAC_BITS - 2;
    localparam int TP_W  = FRAC_BITS + 19;
    localparam int SP_W  = TAB_W + 34;
    localparam logic [FRAC_BITS+1:0] ONE2 = (FRAC_BITS+2)'(1) << FRAC_BITS;

    logic en;

    // sequencer
    logic                r_act;
    t_job                r_cur;
    logic [IDX_W-1:0]    r_j;
    logic [FRAC_BITS:0]  r_t;
    logic [CNT_W-1:0]    r_racc;
    logic                seq_last;
    logic [CNT_W:0]      racc_sum;

    // stage registers
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    t_job r1_job, r2_job, r3_job, r4_job, r5_job, r6_job;
    logic r1_last, r2_last, r3_last, r4_last, r5_last, r6_last, r7_last;
    logic [FRAC_BITS:0]        r1_t;
    logic signed [LP_W-1:0]    r2_lprod;
    logic signed [31:0]        r2_la;
    logic signed [ARG_W-1:0]   r2_arg;
    logic signed [31:0]        r3_lres, r4_lres, r5_lres, r6_lres;
    logic                      r3_neg, r4_neg, r3_sat, r4_sat, r3_par;
    logic [FRAC_BITS+1:0]      r3_fr;
    logic [TAB_W-1:0]          r3_ev, r3_od, r4_tlo;
    logic [TP_W-1:0]           r4_tprod;
    logic signed [TAB_W:0]     r5_sh;
    logic signed [SP_W-1:0]    r6_sprod;
    logic signed [31:0]        r7_val;

    // output and range state
    logic                r_out_vld, r_seen;
    logic signed [31:0]  r_out_val, r_min, r_max;
    logic                r_out_last;

    assign en       = !r_out_vld || i_ready;
    assign o_pop    = en && !r_act && !i_stat.empty;
    assign seq_last = (CNT_W'(r_j) == r_cur.cnt - 1'b1);
    assign racc_sum = {1'b0, r_racc} + {1'b0, r_cur.r_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (en && r_act && seq_last) begin
            r_act <= 1'b0;
        end
    end

    // t = round(j * 2^F / (S-1)) tracked as quotient and remainder of j*2^(F+1)+den over 2*den
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_job;
            r_j    <= '0;
            r_t    <= '0;
            r_racc <= i_job.d2 >> 1;
        end else if (en && r_act) begin
            r_j <= r_j + 1'b1;
            if (racc_sum >= {1'b0, r_cur.d2}) begin
                r_racc <= CNT_W'(racc_sum - {1'b0, r_cur.d2});
                r_t    <= r_t + r_cur.q + 1'b1;
            end else begin
                r_racc <= CNT_W'(racc_sum);
                r_t    <= r_t + r_cur.q;
            end
        end
    end

    // stage 1 -> 2: endpoint select and the two products
    logic [FRAC_BITS+1:0]     t2x;
    logic signed [31:0]       la, lb;
    logic [FRAC_BITS:0]       lu;
    logic signed [32:0]       ldiff;
    logic signed [FRAC_BITS+2:0] dd;

    always_comb begin
        t2x = {r1_t, 1'b0};
        if (r1_job.mode == MODE_LINEAR) begin
            la = r1_job.xs;
            lb = r1_job.xe;
            lu = r1_t;
        end else if (t2x <= ONE2) begin
            la = r1_job.xs;
            lb = r1_job.xb;
            lu = FRAC_BITS'(0) + t2x[FRAC_BITS:0];
        end else begin
            la = r1_job.xb;
            lb = r1_job.xe;
            lu = (FRAC_BITS+1)'(t2x - ONE2);
        end
        ldiff = 33'(lb) - 33'(la);
        dd    = $signed({1'b0, t2x}) - $signed({1'b0, ONE2});
    end

    // stage 2 -> 3: finish lerp, split tanh argument, read table banks
    logic signed [LP_W-1:0]  lrnd;
    logic [ARG_W-1:0]        amag;
    logic [TI_W-1:0]         tidx;
    logic [TAB_AW-2:0]       tm;
    logic [TAB_AW-1:0]       ea;

    always_comb begin
        lrnd = r2_lprod + $signed(LP_W'(1) << (FRAC_BITS - 1));
        amag = r2_arg[ARG_W-1] ? ARG_W'(-r2_arg) : ARG_W'(r2_arg);
        tidx = amag[ARG_W-1:FRAC_BITS+2];
        tm   = tidx[TAB_AW-1:1];
        ea   = tidx[0] ? {1'b0, tm} + 1'b1 : {1'b0, tm};
    end

    // stage 3 -> 4 and later
    logic [TAB_W-1:0]        tlo, thi;
    logic [TAB_W-1:0]        tv;
    logic [TP_W-1:0]         trnd;
    logic signed [SP_W-1:0]  srnd;
    logic signed [33:0]      dv;

    always_comb begin
        tlo  = r3_par ? r3_od : r3_ev;
        thi  = r3_par ? r3_ev : r3_od;
        trnd = r4_tprod + (TP_W'(1) << (FRAC_BITS + 1));
        tv   = r4_sat ? TANH_ONE : TAB_W'(r4_tlo + TAB_W'(trnd >> (FRAC_BITS + 2)));
        srnd = r6_sprod + $signed(SP_W'(1) << 16);
        dv   = 34'(r6_job.xd) + 34'(srnd >>> 17);
        if (dv < 34'(r6_job.lo)) dv = 34'(r6_job.lo);
        if (dv > 34'(r6_job.hi)) dv = 34'(r6_job.hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0; r4_vld <= 1'b0;
            r5_vld <= 1'b0; r6_vld <= 1'b0; r7_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r_act; r2_vld <= r1_vld; r3_vld <= r2_vld; r4_vld <= r3_vld;
            r5_vld <= r4_vld; r6_vld <= r5_vld; r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_job  <= r_cur;
            r1_t    <= r_t;
            r1_last <= seq_last;

            r2_job   <= r1_job;
            r2_last  <= r1_last;
            r2_lprod <= LP_W'(ldiff) * LP_W'($signed({1'b0, lu}));
            r2_la    <= la;
            r2_arg   <= ARG_W'(dd) * ARG_W'($signed({1'b0, r1_job.gain}));

            r3_job  <= r2_job;
            r3_last <= r2_last;
            r3_lres <= r2_la + 32'(lrnd >>> FRAC_BITS);
            r3_neg  <= r2_arg[ARG_W-1];
            r3_sat  <= (tidx >= TI_W'(TANH_STEPS));
            r3_fr   <= amag[FRAC_BITS+1:0];
            r3_par  <= tidx[0];
            r3_ev   <= TANH_EVEN[ea];
            r3_od   <= TANH_ODD[tm];

            r4_job   <= r3_job;
            r4_last  <= r3_last;
            r4_lres  <= r3_lres;
            r4_neg   <= r3_neg;
            r4_sat   <= r3_sat;
            r4_tlo   <= tlo;
            r4_tprod <= TP_W'(thi - tlo) * TP_W'(r3_fr);

            r5_job  <= r4_job;
            r5_last <= r4_last;
            r5_lres <= r4_lres;
            r5_sh   <= r4_neg ? -$signed({1'b0, tv}) : $signed({1'b0, tv});

            r6_job   <= r5_job;
            r6_last  <= r5_last;
            r6_lres  <= r5_lres;
            r6_sprod <= SP_W'(r5_sh) * SP_W'($signed({1'b0, r5_job.span}));

            r7_last <= r6_last;
            r7_val  <= (r6_job.mode == MODE_DRIVE) ? 32'(dv) : r6_lres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_seen    <= 1'b0;
            r_min     <= '0;
            r_max     <= '0;
        end else if (en) begin
            r_out_vld <= r7_vld;
            if (r7_vld) begin
                r_seen <= 1'b1;
                if (!r_seen || r7_val < r_min) r_min <= r7_val;
                if (!r_seen || r7_val > r_max) r_max <= r7_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r7_vld) begin
            r_out_val  <= r7_val;
            r_out_last <= r7_last;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_sample_value = r_out_val;
    assign o_last_of_step = r_out_last;
    assign o_range_min    = r_min;
    assign o_range_max    = r_max;

    `ASSERT_IMPLY(a_seq_index, i_clk, i_rst_n, r_act, CNT_W'(r_j) < r_cur.cnt)
    `ASSERT_IMPLY(a_range_order, i_clk, i_rst_n, r_out_vld, r_min <= r_max)
    `ASSERT_IMPLY(a_range_cover, i_clk, i_rst_n, r_out_vld,
        r_min <= r_out_val && r_out_val <= r_max)
endmodule
`default_nettype wire

@@ design/segment_sample_interpolator.sv @@
// ----------------------------------------------------------------------------
// segment_sample_interpolator
// Expands step records into interpolated position samples.
// ----------------------------------------------------------------------------
// Use:
//   Step request channel: i_valid / o_ready with start, boundary, end, drive
//   point and gain. Each request yields S samples on o_valid / i_ready, S being
//   the configured sample count clamped to 1..64; o_last_of_step marks the
//   final one.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 sets
//   the sample count, index 1 sets mode; other indexes are ignored. Write
//   only while the block is idle.
// Flow:
//   The front takes a request while idle and pushes it into the queue before
//   taking the next; when S differs from the last request it first runs the
//   serial divider that sets the step of t. The back issues one sample a
//   cycle while the receiver is ready, and loads the next request from the
//   queue only after the sample sequencer has issued the last sample of the
//   current one. A request reaches o_valid through the front, queue,
//   sequencer, 7-stage evaluation pipeline and output register.
// Reset clears all control, config to S=16 / boundary mode, range to zero.
// A stalled receiver freezes the whole back pipeline; the two-entry queue
// lets the front keep taking requests meanwhile until it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module segment_sample_interpolator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // step request
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_x_start,
    input  wire logic signed [31:0] i_x_boundary,
    input  wire logic signed [31:0] i_x_end,
    input  wire logic signed [31:0] i_drive_point,
    input  wire logic signed [15:0] i_gain,
    // samples
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_sample_value,
    output logic                    o_last_of_step,
    output logic signed [31:0]      o_range_min,
    output logic signed [31:0]      o_range_max,
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_index,
    input  wire logic [6:0]         i_cfg_data
);
    import ssi_pkg::*;

    logic [6:0]  r_sample_count;
    logic [1:0]  r_mode;

    logic        push, pop;
    t_job        front_job, head_job;
    t_fifo_stat  fifo_stat;

    // config registers; the port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= 7'd16;
            r_mode         <= MODE_BOUNDARY;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SAMPLES) r_sample_count <= i_cfg_data;
            else if (i_cfg_index == CFG_MODE) r_mode <= i_cfg_data[1:0];
        end
    end

    ssi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_x_start      (i_x_start),
        .i_x_boundary   (i_x_boundary),
        .i_x_end        (i_x_end),
        .i_drive_point  (i_drive_point),
        .i_gain         (i_gain),
        .i_sample_count (r_sample_count),
        .i_mode         (r_mode),
        .o_push         (push),
        .o_job          (front_job),
        .i_stat         (fifo_stat)
    );

    // decouples request intake from sample generation
    ssi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (fifo_stat)
    );

    ssi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_stat         (fifo_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_value (o_sample_value),
        .o_last_of_step (o_last_of_step),
        .o_range_min    (o_range_min),
        .o_range_max    (o_range_max)
    );
endmodule
`default_nettype wire
